// ===== src/lsol_pkg.sv =====
// Package for the LRU slot order list: sizes, codes, state and op enums,
// and the link-memory request and result structs. No dependencies.
`default_nettype none
package lsol_pkg;

  localparam int unsigned MaxSlots = 1024;
  localparam int unsigned SlotW    = 10;
  localparam int unsigned FillW    = SlotW + 1;
  localparam int unsigned ApbAw    = 3;
  localparam int unsigned ApbDw    = 32;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [FillW-1:0] fill_t;

  localparam logic ActAlloc = 1'b0;
  localparam logic ActTouch = 1'b1;

  localparam logic CfgWordSlots = 1'b0;

  localparam fill_t FillMax = fill_t'(MaxSlots);

  typedef enum logic [2:0] {
    OpNone,
    OpFirst,
    OpRotate,
    OpAppend,
    OpMove
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StW1,
    StW2,
    StW3,
    StDone
  } state_e;

  typedef struct packed {
    logic  we;
    logic  re;
    slot_t addr;
    slot_t wdata;
  } link_req_t;

  typedef struct packed {
    slot_t slot;
    logic  evicted;
    logic  error;
  } result_t;

endpackage
`default_nettype wire

// ===== src/lsol_link_ram.sv =====
// Single-port link memory, one entry per slot, registered read data.
// Depends on lsol_pkg for the slot width, depth and request struct.
`default_nettype none
module lsol_link_ram (
  input  wire logic               clk_i,
  input  wire lsol_pkg::link_req_t req_i,
  output      lsol_pkg::slot_t     rdata_o
);

  lsol_pkg::slot_t mem [lsol_pkg::MaxSlots];
  lsol_pkg::slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/lsol_seq.sv =====
// Request sequencer: decodes a request, drives the two link memories
// step by step and keeps head, tail and fill count. Depends on lsol_pkg.
`default_nettype none
module lsol_seq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_action_i,
  input  wire lsol_pkg::slot_t     in_slot_i,
  output      logic                in_ready_o,
  input  wire lsol_pkg::fill_t     cap_i,
  input  wire logic                out_free_i,
  output      logic                done_o,
  output      lsol_pkg::result_t   result_o,
  output      lsol_pkg::link_req_t next_req_o,
  output      lsol_pkg::link_req_t prev_req_o,
  input  wire lsol_pkg::slot_t     next_rdata_i,
  input  wire lsol_pkg::slot_t     prev_rdata_i
);

  lsol_pkg::state_e  state_q, state_d;
  lsol_pkg::op_e     op_q, op_d;
  lsol_pkg::result_t res_q, res_d;
  lsol_pkg::slot_t   head_q, head_d;
  lsol_pkg::slot_t   tail_q, tail_d;
  lsol_pkg::fill_t   fill_q, fill_d;
  logic              accept;

  assign accept = in_valid_i && (state_q == lsol_pkg::StIdle);

  // decode
  always_comb begin
    op_d          = lsol_pkg::OpNone;
    res_d.slot    = in_slot_i;
    res_d.evicted = 1'b0;
    res_d.error   = 1'b0;
    if (in_action_i == lsol_pkg::ActAlloc) begin
      priority if (fill_q == '0) begin
        op_d       = lsol_pkg::OpFirst;
        res_d.slot = head_q;
      end else if (fill_q >= cap_i) begin
        op_d          = lsol_pkg::OpRotate;
        res_d.slot    = tail_q;
        res_d.evicted = 1'b1;
      end else begin
        op_d       = lsol_pkg::OpAppend;
        res_d.slot = fill_q[lsol_pkg::SlotW-1:0];
      end
    end else begin
      priority if ({1'b0, in_slot_i} >= fill_q) begin
        res_d.error = 1'b1;
      end else if (in_slot_i == head_q) begin
        op_d = lsol_pkg::OpNone;
      end else if (in_slot_i == tail_q) begin
        op_d = lsol_pkg::OpRotate;
      end else begin
        op_d = lsol_pkg::OpMove;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lsol_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = (op_d == lsol_pkg::OpNone) ? lsol_pkg::StDone : lsol_pkg::StW1;
        end
      end
      lsol_pkg::StW1: begin
        state_d = (op_q == lsol_pkg::OpFirst) ? lsol_pkg::StDone : lsol_pkg::StW2;
      end
      lsol_pkg::StW2: begin
        state_d = (op_q == lsol_pkg::OpMove) ? lsol_pkg::StW3 : lsol_pkg::StDone;
      end
      lsol_pkg::StW3: begin
        state_d = lsol_pkg::StDone;
      end
      lsol_pkg::StDone: begin
        if (out_free_i) begin
          state_d = lsol_pkg::StIdle;
        end
      end
      default: state_d = lsol_pkg::StIdle;
    endcase
  end

  // outputs and link memory steps
  always_comb begin
    in_ready_o = (state_q == lsol_pkg::StIdle);
    done_o     = (state_q == lsol_pkg::StDone);
    next_req_o = '0;
    prev_req_o = '0;
    unique case (state_q)
      lsol_pkg::StIdle: begin
        if (accept && (op_d == lsol_pkg::OpRotate || op_d == lsol_pkg::OpMove)) begin
          next_req_o.re   = 1'b1;
          next_req_o.addr = res_d.slot;
          prev_req_o.re   = 1'b1;
          prev_req_o.addr = res_d.slot;
        end
      end
      lsol_pkg::StW1: begin
        next_req_o.we = 1'b1;
        prev_req_o.we = 1'b1;
        priority if (op_q == lsol_pkg::OpMove) begin
          // unlink the slot
          next_req_o.addr  = prev_rdata_i;
          next_req_o.wdata = next_rdata_i;
          prev_req_o.addr  = next_rdata_i;
          prev_req_o.wdata = prev_rdata_i;
        end else if (op_q == lsol_pkg::OpAppend) begin
          next_req_o.addr  = res_q.slot;
          next_req_o.wdata = head_q;
          prev_req_o.addr  = res_q.slot;
          prev_req_o.wdata = tail_q;
        end else begin
          next_req_o.addr  = tail_q;
          next_req_o.wdata = head_q;
          prev_req_o.addr  = head_q;
          prev_req_o.wdata = tail_q;
        end
      end
      lsol_pkg::StW2: begin
        next_req_o.we = 1'b1;
        prev_req_o.we = 1'b1;
        if (op_q == lsol_pkg::OpRotate) begin
          next_req_o.addr  = prev_rdata_i;
          next_req_o.wdata = res_q.slot;
          prev_req_o.addr  = res_q.slot;
          prev_req_o.wdata = prev_rdata_i;
        end else begin
          next_req_o.addr  = tail_q;
          next_req_o.wdata = res_q.slot;
          prev_req_o.addr  = head_q;
          prev_req_o.wdata = res_q.slot;
        end
      end
      lsol_pkg::StW3: begin
        next_req_o.we    = 1'b1;
        next_req_o.addr  = res_q.slot;
        next_req_o.wdata = head_q;
        prev_req_o.we    = 1'b1;
        prev_req_o.addr  = res_q.slot;
        prev_req_o.wdata = tail_q;
      end
      lsol_pkg::StDone: begin
        next_req_o = '0;
      end
      default: begin
        next_req_o = '0;
      end
    endcase
  end

  // list pointers
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    unique case (state_q)
      lsol_pkg::StW1: begin
        if (op_q == lsol_pkg::OpFirst) begin
          fill_d = lsol_pkg::fill_t'(1);
        end
      end
      lsol_pkg::StW2: begin
        if (op_q == lsol_pkg::OpRotate) begin
          head_d = res_q.slot;
          tail_d = prev_rdata_i;
        end else if (op_q == lsol_pkg::OpAppend) begin
          head_d = res_q.slot;
          fill_d = fill_q + lsol_pkg::fill_t'(1);
        end
      end
      lsol_pkg::StW3: begin
        head_d = res_q.slot;
      end
      default: begin
        head_d = head_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsol_pkg::StIdle;
      op_q    <= lsol_pkg::OpNone;
      head_q  <= '0;
      tail_q  <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
      if (accept) begin
        op_q <= op_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule
`default_nettype wire

// ===== src/lru_slot_order_list.sv =====
// LRU slot order list, top level: APB register, capacity clamp, output
// register and the sequencer with its two link memories. Uses lsol_pkg.
//
// Usage:
//   Requests arrive as beats on the s_axis channel: tuser is the action
//   (0 allocate, 1 touch) and tdata[9:0] the slot to touch. Each request
//   gives one beat on m_axis: tdata[9:0] the slot, tuser[0] evicted,
//   tuser[1] error.
//   One request is worked on at a time; s_axis_tready is low meanwhile.
//   The time to the next possible accept is set by the single port of
//   each link memory: a read of the slot's links for a rotation of the
//   tail or a touch from mid list, then one write per cycle; an error or
//   a touch of the head needs no link memory access. The result beat
//   shows at the edge that raises s_axis_tready again.
//   The output register holds a result while m_axis_tready is low; a
//   new request may be taken meanwhile and waits at its end for space.
//   Reset empties the list and sets slots_in_use to 1024. Write
//   slots_in_use over APB (address 0) only while the block is idle.
`default_nettype none
module lru_slot_order_list (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output      logic                          s_axis_tready_o,
  input  wire logic [lsol_pkg::InDataW-1:0]  s_axis_tdata_i,  // [9:0] slot_index
  input  wire logic                          s_axis_tuser_i,  // [0] action
  output      logic                          m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output      logic [lsol_pkg::OutDataW-1:0] m_axis_tdata_o,  // [9:0] slot
  output      logic [1:0]                    m_axis_tuser_o,  // [0] evicted, [1] error
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lsol_pkg::ApbAw-1:0]    paddr,
  input  wire logic [lsol_pkg::ApbDw-1:0]    pwdata,
  output      logic [lsol_pkg::ApbDw-1:0]    prdata,
  output      logic                          pready
);

  lsol_pkg::fill_t     slots_q;
  lsol_pkg::fill_t     cap;
  logic                cfg_wr;
  logic                out_free;
  logic                done;
  lsol_pkg::result_t   result;
  lsol_pkg::link_req_t next_req, prev_req;
  lsol_pkg::slot_t     next_rdata, prev_rdata;
  logic                out_valid_q;
  lsol_pkg::result_t   out_res_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == lsol_pkg::CfgWordSlots);
  assign prdata = (paddr[2] == lsol_pkg::CfgWordSlots) ?
                  {{(lsol_pkg::ApbDw - lsol_pkg::FillW){1'b0}}, slots_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= lsol_pkg::FillMax;
    end else if (cfg_wr) begin
      slots_q <= pwdata[lsol_pkg::FillW-1:0];
    end
  end

  always_comb begin
    priority if (slots_q == '0) begin
      cap = lsol_pkg::fill_t'(1);
    end else if (slots_q > lsol_pkg::FillMax) begin
      cap = lsol_pkg::FillMax;
    end else begin
      cap = slots_q;
    end
  end

  assign out_free = !out_valid_q || m_axis_tready_i;

  lsol_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_action_i  (s_axis_tuser_i),
    .in_slot_i    (s_axis_tdata_i[lsol_pkg::SlotW-1:0]),
    .in_ready_o   (s_axis_tready_o),
    .cap_i        (cap),
    .out_free_i   (out_free),
    .done_o       (done),
    .result_o     (result),
    .next_req_o   (next_req),
    .prev_req_o   (prev_req),
    .next_rdata_i (next_rdata),
    .prev_rdata_i (prev_rdata)
  );

  lsol_link_ram u_next_ram (
    .clk_i   (clk_i),
    .req_i   (next_req),
    .rdata_o (next_rdata)
  );

  lsol_link_ram u_prev_ram (
    .clk_i   (clk_i),
    .req_i   (prev_req),
    .rdata_o (prev_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && out_free) begin
      out_res_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(lsol_pkg::OutDataW - lsol_pkg::SlotW){1'b0}}, out_res_q.slot};
  assign m_axis_tuser_o  = {out_res_q.error, out_res_q.evicted};

endmodule
`default_nettype wire

// ===== src/lsol_checker.sv =====
// Port-level checks for the LRU slot order list, bound to the top level.
// Depends on lsol_pkg for port widths.
`default_nettype none
module lsol_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid_i,
  input wire logic                          s_axis_tready_o,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i,
  input wire logic [lsol_pkg::OutDataW-1:0] m_axis_tdata_o,
  input wire logic [1:0]                    m_axis_tuser_o
);

  logic       in_beat, out_beat;
  logic [1:0] pend_q;

  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_beat = m_axis_tvalid_o && m_axis_tready_i;

  // count requests whose result beat is still owed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_beat && !out_beat) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_beat && !in_beat) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two requests outstanding");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pend_q != 2'd0)
    else $error("result beat without a request");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready_o)
    else $error("ready right after an accepted request");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("evicted and error together");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result beat changed");

endmodule

bind lru_slot_order_list lsol_checker u_lsol_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
`default_nettype wire
